>>> sv/quadratic_calibration_3axis_defines.svh
// ----------------------------------------------------------------------------
// quadratic calibration assertion macros
// concurrent checks on clk with rst_n low as disable; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_CALIBRATION_3AXIS_DEFINES_SVH
`define QUADRATIC_CALIBRATION_3AXIS_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define QCAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define QCAL_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QCAL_ASSERT(lbl, prop, msg)
`define QCAL_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> sv/qcal_pkg.sv
// ----------------------------------------------------------------------------
// qcal_pkg
// shared types and constants of the three-axis quadratic calibration block
// ----------------------------------------------------------------------------
`default_nettype none

package qcal_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_ROW0   = 3'd0,
        CFG_LIN_ROW1   = 3'd1,
        CFG_LIN_ROW2   = 3'd2,
        CFG_QUAD_ROW0  = 3'd3,
        CFG_QUAD_ROW1  = 3'd4,
        CFG_QUAD_ROW2  = 3'd5,
        CFG_OFFSET_XYZ = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [IN_W-1:0] sample_x;
        logic signed [IN_W-1:0] sample_y;
        logic signed [IN_W-1:0] sample_z;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic                    saturated;
    } result_t;

    // one axis result leaving a lane
    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    clip;
    } lane_res_t;

endpackage

`default_nettype wire

>>> sv/qcal_prep.sv
// ----------------------------------------------------------------------------
// qcal_prep
// registers the sample, takes each axis to SAMPLE_BITS (zero-extended when wider) and forms its square
// ----------------------------------------------------------------------------
`default_nettype none

module qcal_prep #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  qcal_pkg::sample_t          sample,
    output logic signed [SAMPLE_BITS-1:0]   x [3],
    output logic        [2*SAMPLE_BITS-1:0] sq [3]
);
    import qcal_pkg::*;

    logic        [IN_W-1:0]          raw [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]   x_next [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]   x_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]   x_d_reg [NUM_AXES];
    logic signed [2*SAMPLE_BITS-1:0] sq_next [NUM_AXES];
    logic        [2*SAMPLE_BITS-1:0] sq_reg [NUM_AXES];

    assign raw[0] = sample.sample_x;
    assign raw[1] = sample.sample_y;
    assign raw[2] = sample.sample_z;

    // low bits taken as the sample; wider samples see the port zero-extended
    generate
        if (SAMPLE_BITS <= IN_W) begin : g_narrow
            always_comb
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    x_next[j] = raw[j][SAMPLE_BITS-1:0];
                end
            end
        end else begin : g_wide
            always_comb
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    x_next[j] = {{(SAMPLE_BITS-IN_W){1'b0}}, raw[j]};
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            sq_next[j] = x_reg[j] * x_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            x_reg[j]   <= x_next[j];
            x_d_reg[j] <= x_reg[j];
            sq_reg[j]  <= sq_next[j];
        end
    end

    assign x  = x_d_reg;
    assign sq = sq_reg;

endmodule

`default_nettype wire

>>> sv/qcal_lane.sv
// ----------------------------------------------------------------------------
// qcal_lane
// one output axis: linear and quadratic products, aligned adder tree,
// floor shift and saturation to 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module qcal_lane #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 16,
    parameter int LIN_FRAC_BITS  = 14,
    parameter int QUAD_FRAC_BITS = 30
) (
    input  logic                             clk,
    input  logic signed [SAMPLE_BITS-1:0]    x [3],
    input  logic        [2*SAMPLE_BITS-1:0]  sq [3],
    input  logic        [qcal_pkg::CFG_W-1:0] lin_row,
    input  logic        [qcal_pkg::CFG_W-1:0] quad_row,
    input  logic signed [SAMPLE_BITS-1:0]    offset,
    output qcal_pkg::lane_res_t              res
);
    import qcal_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int C    = COEF_BITS;
    localparam int F    = (LIN_FRAC_BITS > QUAD_FRAC_BITS) ? LIN_FRAC_BITS : QUAD_FRAC_BITS;
    localparam int PK_W = 3 * C;
    localparam int LP_W = C + S;
    localparam int QP_W = C + S + 1;
    // widths of the aligned terms
    localparam int OFF_TW = S + F;
    localparam int LIN_TW = LP_W + F - LIN_FRAC_BITS;
    localparam int LO_TW  = QP_W + F - QUAD_FRAC_BITS;
    localparam int HI_TW  = QP_W + S + F - QUAD_FRAC_BITS;
    localparam int MX_A   = (OFF_TW > LIN_TW) ? OFF_TW : LIN_TW;
    localparam int MX_B   = (LO_TW > HI_TW) ? LO_TW : HI_TW;
    // ten terms summed: four guard bits
    localparam int ACC_W  = ((MX_A > MX_B) ? MX_A : MX_B) + 4;
    localparam int SH_W   = ACC_W - F;
    localparam int EXT_W  = (SH_W > OUT_W) ? SH_W : OUT_W + 1;

    logic        [PK_W-1:0]  lin_pk;
    logic        [PK_W-1:0]  quad_pk;
    logic signed [C-1:0]     a_coef [NUM_AXES];
    logic signed [C-1:0]     b_coef [NUM_AXES];

    logic signed [LP_W-1:0]  lin_prod_next [NUM_AXES];
    logic signed [LP_W-1:0]  lin_prod_reg  [NUM_AXES];
    logic signed [QP_W-1:0]  lo_prod_next  [NUM_AXES];
    logic signed [QP_W-1:0]  lo_prod_reg   [NUM_AXES];
    logic signed [QP_W-1:0]  hi_prod_next  [NUM_AXES];
    logic signed [QP_W-1:0]  hi_prod_reg   [NUM_AXES];

    logic signed [ACC_W-1:0] lin_term [NUM_AXES];
    logic signed [ACC_W-1:0] lo_term  [NUM_AXES];
    logic signed [ACC_W-1:0] hi_term  [NUM_AXES];
    logic signed [ACC_W-1:0] off_term;
    logic signed [ACC_W-1:0] pair_next [5];
    logic signed [ACC_W-1:0] pair_reg  [5];
    logic signed [ACC_W-1:0] sum_next  [2];
    logic signed [ACC_W-1:0] sum_reg   [2];

    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  shifted;
    logic signed [EXT_W-1:0] ext;
    logic                    over_pos;
    logic                    over_neg;
    lane_res_t               res_next;
    lane_res_t               res_reg;

    // fields past the top of the register read as zero
    generate
        if (PK_W <= CFG_W) begin : g_pk_fit
            assign lin_pk  = lin_row[PK_W-1:0];
            assign quad_pk = quad_row[PK_W-1:0];
        end else begin : g_pk_pad
            assign lin_pk  = {{(PK_W-CFG_W){1'b0}}, lin_row};
            assign quad_pk = {{(PK_W-CFG_W){1'b0}}, quad_row};
        end
    endgenerate

    // products; the square is split in halves to keep each multiplier narrow
    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            a_coef[j]        = lin_pk[j*C +: C];
            b_coef[j]        = quad_pk[j*C +: C];
            lin_prod_next[j] = a_coef[j] * x[j];
            lo_prod_next[j]  = b_coef[j] * $signed({1'b0, sq[j][S-1:0]});
            hi_prod_next[j]  = b_coef[j] * $signed({1'b0, sq[j][2*S-1:S]});
        end
    end

    // align every term to F fraction bits, first level of the tree
    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            lin_term[j] = ACC_W'(lin_prod_reg[j]) <<< (F - LIN_FRAC_BITS);
            lo_term[j]  = ACC_W'(lo_prod_reg[j]) <<< (F - QUAD_FRAC_BITS);
            hi_term[j]  = ACC_W'(hi_prod_reg[j]) <<< (S + F - QUAD_FRAC_BITS);
        end
        off_term     = ACC_W'(offset) <<< F;
        pair_next[0] = lin_term[0] + lo_term[0];
        pair_next[1] = lin_term[1] + lo_term[1];
        pair_next[2] = lin_term[2] + lo_term[2];
        pair_next[3] = hi_term[0] + hi_term[1];
        pair_next[4] = hi_term[2] + off_term;
    end

    always_comb
    begin
        sum_next[0] = pair_reg[0] + pair_reg[1];
        sum_next[1] = pair_reg[2] + pair_reg[3] + pair_reg[4];
    end

    // final add, floor shift by F, saturate
    always_comb
    begin
        acc      = sum_reg[0] + sum_reg[1];
        shifted  = acc[ACC_W-1:F];
        ext      = EXT_W'(shifted);
        over_pos = !ext[EXT_W-1] && (|ext[EXT_W-2:OUT_W-1]);
        over_neg = ext[EXT_W-1] && !(&ext[EXT_W-2:OUT_W-1]);
        res_next.clip = over_pos || over_neg;
        if (over_pos)
        begin
            res_next.value = OUT_MAX;
        end
        else if (over_neg)
        begin
            res_next.value = OUT_MIN;
        end
        else
        begin
            res_next.value = ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            lin_prod_reg[j] <= lin_prod_next[j];
            lo_prod_reg[j]  <= lo_prod_next[j];
            hi_prod_reg[j]  <= hi_prod_next[j];
        end
        for (int k = 0; k < 5; k++)
        begin
            pair_reg[k] <= pair_next[k];
        end
        sum_reg[0] <= sum_next[0];
        sum_reg[1] <= sum_next[1];
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> sv/qcal_merge.sv
// ----------------------------------------------------------------------------
// qcal_merge
// gathers the three lane results into one result request with its strobe
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_calibration_3axis_defines.svh"

module qcal_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qcal_pkg::lane_res_t lane [3],
    output logic                done,
    output qcal_pkg::result_t   result
);
    import qcal_pkg::*;

    result_t result_next;
    result_t result_reg;
    logic    done_reg;
    logic    any_rail;

    always_comb
    begin
        result_next.out_x     = lane[0].value;
        result_next.out_y     = lane[1].value;
        result_next.out_z     = lane[2].value;
        result_next.saturated = lane[0].clip || lane[1].clip || lane[2].clip;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // some axis sits at a rail
    assign any_rail = (result.out_x == OUT_MAX) || (result.out_x == OUT_MIN) ||
                      (result.out_y == OUT_MAX) || (result.out_y == OUT_MIN) ||
                      (result.out_z == OUT_MAX) || (result.out_z == OUT_MIN);

    // a flagged result has at least one axis pinned at a rail
    `QCAL_ASSERT_NEVER(a_sat_at_rail, done && result.saturated && !any_rail, "saturated flag with no axis at a rail")

endmodule

`default_nettype wire

>>> sv/quadratic_calibration_3axis.sv
// ----------------------------------------------------------------------------
// quadratic_calibration_3axis
// y = A*x + b + B*(x squared per element) on a three-axis sample, fixed point,
// floor-shifted and saturated to signed 32 bits
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+--------------------------------
//  request   | start high, busy low        | sample (sample_x/_y/_z)
//  result    | done strobe, one cycle      | result (out_x/_y/_z, saturated)
//  config    | cfg_wr_en high              | cfg_index, cfg_data
//
//  one request per clock while busy is low; fully pipelined, no state carried between samples
//  pipeline registers, in order: input register, square, products, two
//  adder levels, final add and saturate, output register
//  busy is high only from reset until its register clears once reset is released
//  the receiver cannot stall, so results never wait
//  configuration must be written by the user (the block does not enforce it) only with no request in flight
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_calibration_3axis_defines.svh"

module quadratic_calibration_3axis #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 16,
    parameter int LIN_FRAC_BITS  = 14,
    parameter int QUAD_FRAC_BITS = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  qcal_pkg::sample_t               sample,
    output logic                            done,
    output qcal_pkg::result_t               result,
    input  logic                            cfg_wr_en,
    input  logic [qcal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qcal_pkg::CFG_W-1:0]      cfg_data
);
    import qcal_pkg::*;

    // valid stages ahead of the merge register: x, square, products,
    // pair sums, partial sums, lane result
    localparam int PIPE_STAGES = 6;
    localparam int OFF_PK_W    = 3 * SAMPLE_BITS;

    logic                       accept;
    logic                       busy_reg;
    logic [PIPE_STAGES-1:0]     vld_next;
    logic [PIPE_STAGES-1:0]     vld_reg;

    // configuration registers
    logic [CFG_W-1:0]           lin_row_next  [NUM_AXES];
    logic [CFG_W-1:0]           lin_row_reg   [NUM_AXES];
    logic [CFG_W-1:0]           quad_row_next [NUM_AXES];
    logic [CFG_W-1:0]           quad_row_reg  [NUM_AXES];
    logic [CFG_W-1:0]           offset_next;
    logic [CFG_W-1:0]           offset_reg;
    logic [OFF_PK_W-1:0]        offset_pk;
    logic signed [SAMPLE_BITS-1:0] offset_axis [NUM_AXES];

    logic signed [SAMPLE_BITS-1:0]   x  [NUM_AXES];
    logic        [2*SAMPLE_BITS-1:0] sq [NUM_AXES];
    lane_res_t                       lane_res [NUM_AXES];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // ---------------- configuration write port
    always_comb
    begin
        lin_row_next  = lin_row_reg;
        quad_row_next = quad_row_reg;
        offset_next   = offset_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LIN_ROW0:   lin_row_next[0]  = cfg_data;
                CFG_LIN_ROW1:   lin_row_next[1]  = cfg_data;
                CFG_LIN_ROW2:   lin_row_next[2]  = cfg_data;
                CFG_QUAD_ROW0:  quad_row_next[0] = cfg_data;
                CFG_QUAD_ROW1:  quad_row_next[1] = cfg_data;
                CFG_QUAD_ROW2:  quad_row_next[2] = cfg_data;
                CFG_OFFSET_XYZ: offset_next      = cfg_data;
                default:        ;   // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                lin_row_reg[i]  <= '0;
                quad_row_reg[i] <= '0;
            end
            offset_reg <= '0;
        end
        else
        begin
            lin_row_reg  <= lin_row_next;
            quad_row_reg <= quad_row_next;
            offset_reg   <= offset_next;
        end
    end

    // offset fields past bit 47 read as zero
    generate
        if (OFF_PK_W <= CFG_W) begin : g_off_fit
            assign offset_pk = offset_reg[OFF_PK_W-1:0];
        end else begin : g_off_pad
            assign offset_pk = {{(OFF_PK_W-CFG_W){1'b0}}, offset_reg};
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            offset_axis[i] = offset_pk[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // ---------------- request tracking
    assign vld_next = {vld_reg[PIPE_STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= vld_next;
        end
    end

    // ---------------- datapath
    // shared front end: sample register and squares
    qcal_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .clk    (clk),
        .sample (sample),
        .x      (x),
        .sq     (sq)
    );

    // one lane per output axis, all fed the same sample
    generate
        for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
            qcal_lane #(
                .SAMPLE_BITS    (SAMPLE_BITS),
                .COEF_BITS      (COEF_BITS),
                .LIN_FRAC_BITS  (LIN_FRAC_BITS),
                .QUAD_FRAC_BITS (QUAD_FRAC_BITS)
            ) u_lane (
                .clk      (clk),
                .x        (x),
                .sq       (sq),
                .lin_row  (lin_row_reg[g]),
                .quad_row (quad_row_reg[g]),
                .offset   (offset_axis[g]),
                .res      (lane_res[g])
            );
        end
    endgenerate

    // combine lane results and saturation flags into one result
    qcal_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[PIPE_STAGES-1]),
        .lane     (lane_res),
        .done     (done),
        .result   (result)
    );

    // every accepted request comes out as a done strobe after the valid stages and the merge register
    `QCAL_ASSERT(a_latency, accept |-> ##(PIPE_STAGES + 1) done, "request lost in pipeline")
    // no strobe without a request behind it
    `QCAL_ASSERT(a_no_phantom, !vld_reg[PIPE_STAGES-1] |=> !done, "result strobe without request")
    // an index past the last register leaves the offsets alone
    `QCAL_ASSERT(a_bad_index, cfg_wr_en && cfg_index > CFG_OFFSET_XYZ |=> $stable(offset_reg), "unknown index wrote a register")

endmodule

`default_nettype wire
